// ===== design/cwmm_pkg.sv =====
package cwmm_pkg;

    // Fixed field widths of the sample and result beats.
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 32;
    localparam int FILL_W    = 5;

    // Limit register file: one 64-bit register per channel slot.
    localparam int NUM_LIMIT_REGS = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int LIMIT_W        = 64;
    localparam logic [LIMIT_W-1:0] LIMITS_RESET = 64'h7FFF_FFFF_8000_0000;

    // Default sizing of the ring store.
    localparam int WINDOW_DEF   = 16;
    localparam int CHANNELS_DEF = 8;

endpackage

// ===== design/channel_window_min_max_range_check_unit.sv =====
// Sequence: an accepted sample beat is written into its channel's ring, which is then read once per
// stored entry (n, the channel's fill count after the write, up to WINDOW) through the single read
// port to find the window minimum and maximum; the result goes to the output register once that
// register is free. No new sample is taken until then, so a held output also stalls the input.
// Reset: rst_n is asynchronous and active low; it clears every head pointer and fill count
// and sets all limits to the widest range. The ring memory itself is not cleared.
module channel_window_min_max_range_check_unit #(
    parameter int WINDOW   = cwmm_pkg::WINDOW_DEF,
    parameter int CHANNELS = cwmm_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cwmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cwmm_pkg::LIMIT_W-1:0]          cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cwmm_pkg::CHAN_W-1:0]           channel,
    input  logic signed [cwmm_pkg::SAMPLE_W-1:0]  sample,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cwmm_pkg::CHAN_W-1:0]           out_channel,
    output logic signed [cwmm_pkg::SAMPLE_W-1:0]  window_min,
    output logic signed [cwmm_pkg::SAMPLE_W-1:0]  window_max,
    output logic [cwmm_pkg::FILL_W-1:0]           fill_count,
    output logic                                  out_of_range
);

    // Ring index, fill count, channel select and flat memory address widths.
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // The sequencer: IDLE takes a sample and writes it into the ring (a sample for an unconfigured
    // channel goes straight to PUT unwritten), SCAN issues one ring read per stored entry, LAST folds
    // the final read, PUT hands the result to the output register as soon as that register is free.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_PUT
    } state_t;

    state_t                              state_reg, state_next;

    logic [IDX_W-1:0]                    head_reg  [CHANNELS];
    logic [IDX_W-1:0]                    head_next [CHANNELS];
    logic [CNT_W-1:0]                    count_reg  [CHANNELS];
    logic [CNT_W-1:0]                    count_next [CHANNELS];
    logic [cwmm_pkg::LIMIT_W-1:0]        limits_reg  [cwmm_pkg::NUM_LIMIT_REGS];
    logic [cwmm_pkg::LIMIT_W-1:0]        limits_next [cwmm_pkg::NUM_LIMIT_REGS];

    // Working registers of the item in flight.
    logic [cwmm_pkg::CHAN_W-1:0]         ch_reg, ch_next;
    logic                                bad_ch_reg, bad_ch_next;
    logic                                oor_reg, oor_next;
    logic [CNT_W-1:0]                    n_reg, n_next;
    logic [IDX_W-1:0]                    rd_idx_reg, rd_idx_next;
    logic                                rd_pend_reg, rd_pend_next;
    logic                                first_reg, first_next;
    logic signed [cwmm_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic signed [cwmm_pkg::SAMPLE_W-1:0] max_reg, max_next;

    // Output register, parting the scan from the downstream side.
    logic                                out_valid_reg, out_valid_next;
    logic [cwmm_pkg::CHAN_W-1:0]         out_channel_reg, out_channel_next;
    logic signed [cwmm_pkg::SAMPLE_W-1:0] out_min_reg, out_min_next;
    logic signed [cwmm_pkg::SAMPLE_W-1:0] out_max_reg, out_max_next;
    logic [cwmm_pkg::FILL_W-1:0]         out_fill_reg, out_fill_next;
    logic                                out_oor_reg, out_oor_next;

    // Ring memory: one write port, one read port, registered read data.
    logic signed [cwmm_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
    logic signed [cwmm_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                                mem_we;
    logic                                mem_re;
    logic [ADDR_W-1:0]                   wr_addr;
    logic [ADDR_W-1:0]                   rd_addr;

    // Decode of the incoming beat.
    logic                                in_ch_ok;
    logic [CH_W-1:0]                     in_sel;
    logic [CH_W-1:0]                     cur_sel;
    logic [IDX_W-1:0]                    in_head;
    logic [CNT_W-1:0]                    in_count;
    logic signed [31:0]                  lim_lo;
    logic signed [31:0]                  lim_hi;
    logic                                scan_last;
    logic                                out_free;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign window_min   = out_min_reg;
    assign window_max   = out_max_reg;
    assign fill_count   = out_fill_reg;
    assign out_of_range = out_oor_reg;

    assign in_ch_ok  = (32'(channel) < CHANNELS);
    assign in_sel    = CH_W'(channel);
    assign cur_sel   = CH_W'(ch_reg);
    assign in_head   = head_reg[in_sel];
    assign in_count  = count_reg[in_sel];
    assign lim_lo    = signed'(limits_reg[channel][31:0]);
    assign lim_hi    = signed'(limits_reg[channel][63:32]);
    assign scan_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == n_reg);
    assign out_free  = !out_valid_reg || out_ready;

    // Entries of channel c sit at c * WINDOW + index in the flat memory. The write of a
    // new sample happens on the accept edge in IDLE and scan reads are issued only in SCAN, so
    // a read never meets a write to the same entry in the same cycle.
    assign wr_addr = ADDR_W'(32'(in_sel) * WINDOW + 32'(in_head));
    assign rd_addr = ADDR_W'(32'(cur_sel) * WINDOW + 32'(rd_idx_reg));

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        limits_next      = limits_reg;
        ch_next          = ch_reg;
        bad_ch_next      = bad_ch_reg;
        oor_next         = oor_reg;
        n_next           = n_reg;
        rd_idx_next      = rd_idx_reg;
        first_next       = first_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        out_valid_next   = out_valid_reg;
        out_channel_next = out_channel_reg;
        out_min_next     = out_min_reg;
        out_max_next     = out_max_reg;
        out_fill_next    = out_fill_reg;
        out_oor_next     = out_oor_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        // The user must write limits only while the block is idle; the block itself does not enforce this.
        if (cfg_valid)
        begin
            limits_next[cfg_index] = cfg_data;
        end

        // Fold the read that returned this cycle into the running minimum and maximum.
        if (rd_pend_reg)
        begin
            if (first_reg)
            begin
                min_next   = rd_data_reg;
                max_next   = rd_data_reg;
                first_next = 1'b0;
            end
            else
            begin
                if (rd_data_reg < min_reg)
                begin
                    min_next = rd_data_reg;
                end
                if (rd_data_reg > max_reg)
                begin
                    max_next = rd_data_reg;
                end
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next     = channel;
                    oor_next    = (sample < lim_lo) || (sample > lim_hi);
                    rd_idx_next = '0;
                    first_next  = 1'b1;
                    if (in_ch_ok)
                    begin
                        mem_we      = 1'b1;
                        bad_ch_next = 1'b0;
                        if (in_head == IDX_W'(WINDOW - 1))
                        begin
                            head_next[in_sel] = '0;
                        end
                        else
                        begin
                            head_next[in_sel] = in_head + IDX_W'(1);
                        end
                        if (in_count != CNT_W'(WINDOW))
                        begin
                            count_next[in_sel] = in_count + CNT_W'(1);
                            n_next             = in_count + CNT_W'(1);
                        end
                        else
                        begin
                            n_next = in_count;
                        end
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // A channel beyond the configured count leaves the rings, heads and fill counts untouched.
                        bad_ch_next = 1'b1;
                        state_next  = ST_PUT;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_re = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = ch_reg;
                    if (bad_ch_reg)
                    begin
                        out_min_next  = '0;
                        out_max_next  = '0;
                        out_fill_next = '0;
                        out_oor_next  = 1'b0;
                    end
                    else
                    begin
                        out_min_next  = min_reg;
                        out_max_next  = max_reg;
                        out_fill_next = cwmm_pkg::FILL_W'(n_reg);
                        out_oor_next  = oor_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_pend_next = mem_re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            for (int r = 0; r < cwmm_pkg::NUM_LIMIT_REGS; r++)
            begin
                limits_reg[r] <= cwmm_pkg::LIMITS_RESET;
            end
            ch_reg          <= '0;
            bad_ch_reg      <= 1'b0;
            oor_reg         <= 1'b0;
            n_reg           <= '0;
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            first_reg       <= 1'b0;
            min_reg         <= '0;
            max_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_min_reg     <= '0;
            out_max_reg     <= '0;
            out_fill_reg    <= '0;
            out_oor_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            limits_reg      <= limits_next;
            ch_reg          <= ch_next;
            bad_ch_reg      <= bad_ch_next;
            oor_reg         <= oor_next;
            n_reg           <= n_next;
            rd_idx_reg      <= rd_idx_next;
            rd_pend_reg     <= rd_pend_next;
            first_reg       <= first_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            out_valid_reg   <= out_valid_next;
            out_channel_reg <= out_channel_next;
            out_min_reg     <= out_min_next;
            out_max_reg     <= out_max_next;
            out_fill_reg    <= out_fill_next;
            out_oor_reg     <= out_oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_addr] <= sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // A sample for a configured channel always starts a scan on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_ch_ok) |=> (state_reg == ST_SCAN))
    else $error("accepted sample did not start a ring scan");

    // A scan only runs over a non-empty window that fits the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (n_reg != '0) && (32'(n_reg) <= WINDOW))
    else $error("ring scan with an impossible fill count");

    // The first fold of every scan comes from the read issued at entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pend_reg && first_reg) |-> ($past(rd_idx_reg) == '0))
    else $error("first folded sample did not come from entry zero");

    // A result beat appears only after the sequencer passed through its hand-off state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PUT))
    else $error("result beat raised outside the hand-off state");

    // A result for a configured channel always reports at least one stored sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (32'(out_channel_reg) < CHANNELS)) |-> (out_fill_reg != '0))
    else $error("result for a configured channel with an empty window");
`endif

endmodule
